// ===== design/ffcg_pkg.sv =====
// Shared types, constants and helpers for the far-field characteristic ghost-state pipeline.
// No dependencies; every other design file imports this package.
package ffcg_pkg;

	// Quotient bits kept by the dividers; anything at or above 2^QB saturates to MAG_CAP.
	localparam int QB     = 33;
	localparam int MAG_W  = QB + 1;
	localparam int ACC_W  = 38;
	localparam int DEN_W  = 62;
	localparam int WMAG_W = 50;

	localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {QB{1'b0}}};

	localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

	typedef enum logic [1:0] {
		REG_SUP_IN  = 2'd0,
		REG_SUB_IN  = 2'd1,
		REG_SUB_OUT = 2'd2,
		REG_SUP_OUT = 2'd3
	} regime_t;

	typedef struct packed {
		regime_t            regime;
		logic signed [31:0] r;
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic signed [31:0] p;
		logic               pneg;
		logic               nxneg;
		logic               nyneg;
		logic               wneg;
	} side_t;

	function automatic logic signed [ACC_W-1:0] signed_mag(input logic [MAG_W-1:0] m,
			input logic neg);
		logic signed [ACC_W-1:0] x;
		x = $signed(ACC_W'(m));
		return neg ? -x : x;
	endfunction

	function automatic logic signed [ACC_W-1:0] widen(input logic signed [31:0] x);
		return ACC_W'(x);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [31:0] y;
		if (x > SAT_HI) begin
			y = SAT_HI[31:0];
		end else if (x < SAT_LO) begin
			y = SAT_LO[31:0];
		end else begin
			y = x[31:0];
		end
		return y;
	endfunction

endpackage

// ===== design/farfield_char_ghost_state_2d_core.sv =====
// Top level of the far-field characteristic ghost-state pipeline.
// Depends on ffcg_pkg, ffcg_front, ffcg_div and ffcg_outflow.
//
// Usage:
//   Request channel (pt_valid/pt_ready) carries one boundary point: mean flow, interior
//   perturbations and unit outward normal, all Q.FRAC_BITS. Result channel
//   (gh_valid/gh_ready) returns the ghost perturbations, saturated to 32 bits, and the
//   flow regime (supersonic inflow, subsonic inflow, subsonic outflow, supersonic outflow).
//   Every request gives exactly one result, in order.
// Pipeline:
//   Two front stages (products, then classification), 34 divider
//   stages (overflow check plus one quotient bit per stage, 33 bits) and the output register.
//   Throughput is one request per cycle while the result is not stalled; the three dividers are fully pipelined.
// Stall:
//   The whole pipeline advances together. When a result waits and gh_ready is low, every
//   stage holds and pt_ready drops; nothing is dropped or repeated. Bubbles advance freely.
// Reset:
//   arst_n clears all valid bits at once; the block takes requests right after.
module farfield_char_ghost_state_2d_core import ffcg_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pt_valid,
	output logic               pt_ready,
	input  logic [30:0]        mean_density,
	input  logic signed [31:0] mean_vel_x,
	input  logic signed [31:0] mean_vel_y,
	input  logic [30:0]        sound_speed,
	input  logic signed [31:0] pert_density,
	input  logic signed [31:0] pert_vel_x,
	input  logic signed [31:0] pert_vel_y,
	input  logic signed [31:0] pert_pressure,
	input  logic signed [17:0] normal_x,
	input  logic signed [17:0] normal_y,
	output logic               gh_valid,
	input  logic               gh_ready,
	output logic signed [31:0] ghost_density,
	output logic signed [31:0] ghost_vel_x,
	output logic signed [31:0] ghost_vel_y,
	output logic signed [31:0] ghost_pressure,
	output logic [1:0]         flow_regime
);

	// Numerators: |p| << 2F and |p*n| << F, both fit here.
	localparam int NUM_W = 2 * FRAC_BITS + 50;
	localparam int DLAT  = QB + 1;

	logic en;

	// advance whenever the output register is empty or being drained
	assign en       = !gh_valid || gh_ready;
	assign pt_ready = en;

	logic              vld_s2;
	side_t             side_s2;
	logic [NUM_W-1:0]  num_rho_s2, num_u_s2, num_v_s2;
	logic [DEN_W-1:0]  c0sq_s2, imp_s2;
	logic [WMAG_W-1:0] wmag_s2;

	ffcg_front #(
		.FRAC_BITS (FRAC_BITS),
		.NUM_W     (NUM_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.pt_valid      (pt_valid),
		.mean_density  (mean_density),
		.mean_vel_x    (mean_vel_x),
		.mean_vel_y    (mean_vel_y),
		.sound_speed   (sound_speed),
		.pert_density  (pert_density),
		.pert_vel_x    (pert_vel_x),
		.pert_vel_y    (pert_vel_y),
		.pert_pressure (pert_pressure),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.vld_s2        (vld_s2),
		.side_s2       (side_s2),
		.num_rho_s2    (num_rho_s2),
		.num_u_s2      (num_u_s2),
		.num_v_s2      (num_v_s2),
		.c0sq_s2       (c0sq_s2),
		.imp_s2        (imp_s2),
		.wmag_s2       (wmag_s2)
	);

	// Subsonic inflow quotients: density from p / c0^2, velocities from p*n / (rho0*c0).
	logic [MAG_W-1:0] rho_mag, u_mag, v_mag, p_mag;

	ffcg_div #(.NUM_W(NUM_W)) u_div_rho (
		.clk (clk),
		.en  (en),
		.num (num_rho_s2),
		.den (c0sq_s2),
		.mag (rho_mag)
	);

	ffcg_div #(.NUM_W(NUM_W)) u_div_u (
		.clk (clk),
		.en  (en),
		.num (num_u_s2),
		.den (imp_s2),
		.mag (u_mag)
	);

	ffcg_div #(.NUM_W(NUM_W)) u_div_v (
		.clk (clk),
		.en  (en),
		.num (num_v_s2),
		.den (imp_s2),
		.mag (v_mag)
	);

	// Subsonic outflow pressure term, delayed to line up with the dividers.
	ffcg_outflow #(
		.FRAC_BITS (FRAC_BITS),
		.LAT       (DLAT)
	) u_outflow (
		.clk  (clk),
		.en   (en),
		.wmag (wmag_s2),
		.imp  (imp_s2),
		.pm   (p_mag)
	);

	// Side data and valid bits ride alongside the divider stages.
	side_t side_s [DLAT];
	logic  vld_s  [DLAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DLAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= vld_s2;
			for (int k = 1; k < DLAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_s2;
			for (int k = 1; k < DLAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	side_t                   sd;
	logic signed [ACC_W-1:0] rq, uq, vq, pq;
	logic signed [ACC_W-1:0] gr, gu, gv, gp;

	assign sd = side_s[DLAT-1];
	assign rq = signed_mag(rho_mag, sd.pneg);
	// velocity term is negative when p and the normal component share a sign
	assign uq = signed_mag(u_mag, sd.pneg == sd.nxneg);
	assign vq = signed_mag(v_mag, sd.pneg == sd.nyneg);
	assign pq = signed_mag(p_mag, sd.wneg);

	always_comb begin
		case (sd.regime)
			REG_SUP_IN: begin
				gr = -widen(sd.r);
				gu = -widen(sd.u);
				gv = -widen(sd.v);
				gp = -widen(sd.p);
			end
			REG_SUB_IN: begin
				gr = (rq <<< 1) - widen(sd.r);
				gu = (uq <<< 1) - widen(sd.u);
				gv = (vq <<< 1) - widen(sd.v);
				gp = widen(sd.p);
			end
			REG_SUB_OUT: begin
				gr = widen(sd.r);
				gu = widen(sd.u);
				gv = widen(sd.v);
				gp = (pq <<< 1) - widen(sd.p);
			end
			default: begin
				gr = widen(sd.r);
				gu = widen(sd.u);
				gv = widen(sd.v);
				gp = widen(sd.p);
			end
		endcase
	end

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gh_valid <= 1'b0;
		end else if (en) begin
			gh_valid <= vld_s[DLAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ghost_density  <= sat32(gr);
			ghost_vel_x    <= sat32(gu);
			ghost_vel_y    <= sat32(gv);
			ghost_pressure <= sat32(gp);
			flow_regime    <= sd.regime;
		end
	end

endmodule

// ===== design/ffcg_front.sv =====
// Front end: products of the boundary point (stage 1), regime and numerators (stage 2).
// Depends on ffcg_pkg.
module ffcg_front import ffcg_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int NUM_W     = 82
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     pt_valid,
	input  logic [30:0]              mean_density,
	input  logic signed [31:0]       mean_vel_x,
	input  logic signed [31:0]       mean_vel_y,
	input  logic [30:0]              sound_speed,
	input  logic signed [31:0]       pert_density,
	input  logic signed [31:0]       pert_vel_x,
	input  logic signed [31:0]       pert_vel_y,
	input  logic signed [31:0]       pert_pressure,
	input  logic signed [17:0]       normal_x,
	input  logic signed [17:0]       normal_y,
	output logic                     vld_s2,
	output side_t                    side_s2,
	output logic [NUM_W-1:0]         num_rho_s2,
	output logic [NUM_W-1:0]         num_u_s2,
	output logic [NUM_W-1:0]         num_v_s2,
	output logic [DEN_W-1:0]         c0sq_s2,
	output logic [DEN_W-1:0]         imp_s2,
	output logic [WMAG_W-1:0]        wmag_s2
);

	localparam int CMP_W = FRAC_BITS + 52;

	logic signed [49:0] su, sv, wu, wv;
	logic [31:0]        ap;
	logic [17:0]        nxm, nym;

	assign su  = mean_vel_x * normal_x;
	assign sv  = mean_vel_y * normal_y;
	assign wu  = pert_vel_x * normal_x;
	assign wv  = pert_vel_y * normal_y;
	assign ap  = pert_pressure[31] ? 32'(-pert_pressure) : 32'(pert_pressure);
	assign nxm = normal_x[17] ? 18'(-normal_x) : 18'(normal_x);
	assign nym = normal_y[17] ? 18'(-normal_y) : 18'(normal_y);

	logic                vld_s1;
	logic signed [49:0]  su_s1, sv_s1, wu_s1, wv_s1;
	logic [DEN_W-1:0]    c0sq_s1, imp_s1;
	logic [49:0]         apnx_s1, apny_s1;
	logic [31:0]         ap_s1;
	logic [30:0]         c0_s1;
	logic signed [31:0]  r_s1, u_s1, v_s1, p_s1;
	logic                nxneg_s1, nyneg_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pt_valid;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: one multiplier per product
	always_ff @(posedge clk) begin
		if (en) begin
			su_s1    <= su;
			sv_s1    <= sv;
			wu_s1    <= wu;
			wv_s1    <= wv;
			c0sq_s1  <= DEN_W'(sound_speed) * DEN_W'(sound_speed);
			imp_s1   <= DEN_W'(mean_density) * DEN_W'(sound_speed);
			apnx_s1  <= 50'(ap) * 50'(nxm);
			apny_s1  <= 50'(ap) * 50'(nym);
			ap_s1    <= ap;
			c0_s1    <= sound_speed;
			r_s1     <= pert_density;
			u_s1     <= pert_vel_x;
			v_s1     <= pert_vel_y;
			p_s1     <= pert_pressure;
			nxneg_s1 <= normal_x[17];
			nyneg_s1 <= normal_y[17];
		end
	end

	logic signed [CMP_W-1:0] s_sum, t_lim;
	logic signed [50:0]      w_sum;
	regime_t                 regime;

	assign s_sum = CMP_W'(su_s1) + CMP_W'(sv_s1);
	assign t_lim = $signed(CMP_W'({c0_s1, {FRAC_BITS{1'b0}}}));
	assign w_sum = 51'(wu_s1) + 51'(wv_s1);

	always_comb begin
		if (s_sum < -t_lim) begin
			regime = REG_SUP_IN;
		end else if (s_sum < 0) begin
			regime = REG_SUB_IN;
		end else if (s_sum < t_lim) begin
			regime = REG_SUB_OUT;
		end else begin
			regime = REG_SUP_OUT;
		end
	end

	// stage 2: classify, form numerators and |u*nx + v*ny|
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.regime <= regime;
			side_s2.r      <= r_s1;
			side_s2.u      <= u_s1;
			side_s2.v      <= v_s1;
			side_s2.p      <= p_s1;
			side_s2.pneg   <= p_s1[31];
			side_s2.nxneg  <= nxneg_s1;
			side_s2.nyneg  <= nyneg_s1;
			side_s2.wneg   <= w_sum[50];
			num_rho_s2     <= NUM_W'(ap_s1) << (2 * FRAC_BITS);
			num_u_s2       <= NUM_W'(apnx_s1) << FRAC_BITS;
			num_v_s2       <= NUM_W'(apny_s1) << FRAC_BITS;
			c0sq_s2        <= c0sq_s1;
			imp_s2         <= imp_s1;
			wmag_s2        <= w_sum[50] ? WMAG_W'(-w_sum) : WMAG_W'(w_sum);
		end
	end

endmodule

// ===== design/ffcg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow cap.
// Depends on ffcg_pkg.
module ffcg_div import ffcg_pkg::*; #(
	parameter int NUM_W = 82
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [MAG_W-1:0] mag
);

	logic [NUM_W-1:0] rem_s [QB+1];
	logic [NUM_W-1:0] den_s [QB+1];
	logic [QB-1:0]    quo_s [QB+1];
	logic             ovf_s [QB+1];

	// entry stage: flag quotients of 2^QB and more (zero divisor included)
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= NUM_W'(den);
			quo_s[0] <= '0;
			ovf_s[0] <= (num != '0) && ((num >> QB) >= NUM_W'(den));
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB - 1 - k;
		logic ge;
		// a zero divisor with a zero numerator yields a zero quotient
		assign ge = (den_s[k] != '0) && ((rem_s[k] >> B) >= den_s[k]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_s[k] - (den_s[k] << B) : rem_s[k];
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign mag = ovf_s[QB] ? MAG_CAP : {1'b0, quo_s[QB]};

endmodule

// ===== design/ffcg_outflow.sv =====
// Outflow pressure term |w| * rho0 * c0 >> 3F, split into partial products, then aligned.
// Depends on ffcg_pkg.
module ffcg_outflow import ffcg_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int LAT       = 34
) (
	input  logic              clk,
	input  logic              en,
	input  logic [WMAG_W-1:0] wmag,
	input  logic [DEN_W-1:0]  imp,
	output logic [MAG_W-1:0]  pm
);

	localparam int SH = 3 * FRAC_BITS;

	logic [55:0]      pll_s1, plh_s1, phl_s1, phh_s1;
	logic [111:0]     sum_s2;
	logic [MAG_W-1:0] dly_s [LAT-2];

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= 56'(imp[30:0]) * 56'(wmag[24:0]);
			plh_s1 <= 56'(imp[30:0]) * 56'(wmag[49:25]);
			phl_s1 <= 56'(imp[61:31]) * 56'(wmag[24:0]);
			phh_s1 <= 56'(imp[61:31]) * 56'(wmag[49:25]);
			sum_s2 <= 112'(pll_s1) + (112'(plh_s1) << 25) + (112'(phl_s1) << 31)
				+ (112'(phh_s1) << 56);
			dly_s[0] <= (|sum_s2[111:SH+QB]) ? MAG_CAP : {1'b0, sum_s2[SH+QB-1:SH]};
		end
	end

	for (genvar k = 1; k < LAT - 2; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				dly_s[k] <= dly_s[k-1];
			end
		end
	end

	assign pm = dly_s[LAT-3];

endmodule
